/* src/gau_pkg.sv */
// Package: operation codes and field lookup tables for the GF(2^8) arithmetic unit.
`timescale 1ns / 1ps

package gau_pkg;

  localparam int unsigned GF_BITS = 8;
  localparam int unsigned GF_ORDER = 255;
  localparam logic [8:0] GF_POLY = 9'h11B;
  localparam logic [7:0] GF_GEN = 8'h03;

  typedef logic [GF_BITS-1:0] gf_elem_t;
  typedef logic [255:0][GF_BITS-1:0] gf_tbl_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  // Multiply by x with reduction.
  function automatic gf_elem_t gf_xtime(input gf_elem_t v);
    logic [8:0] w;
    begin
      w = {v, 1'b0};
      if (w[8]) begin
        w = w ^ GF_POLY;
      end
      return w[7:0];
    end
  endfunction

  // Antilog table: exp[i] = GF_GEN^i, with exp[255] wrapping to 1.
  function automatic gf_tbl_t gf_build_exp();
    gf_tbl_t t;
    gf_elem_t e;
    begin
      t = '0;
      e = 8'h01;
      for (int i = 0; i < 256; i++) begin
        t[i] = e;
        e = (GF_GEN == 8'h03) ? (e ^ gf_xtime(e)) : e;
      end
      return t;
    end
  endfunction

  // Log table: log[0] is unused and reads as 0.
  function automatic gf_tbl_t gf_build_log();
    gf_tbl_t t;
    gf_elem_t e;
    begin
      t = '0;
      e = 8'h01;
      for (int i = 0; i < GF_ORDER; i++) begin
        t[e] = i[7:0];
        e = e ^ gf_xtime(e);
      end
      return t;
    end
  endfunction

  localparam gf_tbl_t GF_EXP = gf_build_exp();
  localparam gf_tbl_t GF_LOG = gf_build_log();

endpackage

/* src/gf256_arithmetic_unit.sv */
// Top level: three-stage pipelined GF(2^8) add, subtract, multiply and divide.
// Throughput: one item per cycle while out_stall does not hold the output; log ROM, mod-255 exponent add, antilog ROM.
// Stalls back up stage by stage; empty stages fill even while the output is held.
// Reset (rst_n low, synchronous) clears every stage's valid bit; data regs keep junk.
`timescale 1ns / 1ps

module gf256_arithmetic_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_left_operand,
  input  logic [7:0] in_right_operand,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_field_result,
  output logic       out_divide_by_zero
);
  import gau_pkg::*;

  // Stage 1: logs of both operands, zero detection, XOR result.
  logic       s1_valid_r;
  logic       s1_sum_r;       // add or subtract: take the XOR path
  logic       s1_zero_r;      // result forced to zero
  logic       s1_dz_r;
  gf_elem_t   s1_xor_r;
  gf_elem_t   s1_log_a_r;
  gf_elem_t   s1_log_b_r;     // log b for multiply, 255 - log b for divide

  // Stage 2: exponent reduced mod 255.
  logic       s2_valid_r;
  logic       s2_sum_r;
  logic       s2_zero_r;
  logic       s2_dz_r;
  gf_elem_t   s2_xor_r;
  gf_elem_t   s2_exp_r;

  // Stage 3: output register.
  logic       out_valid_r;
  gf_elem_t   out_result_r;
  logic       out_dz_r;

  logic       en1, en2, en3;

  // Advance a stage when it is empty or the stage after it advances.
  assign en3 = !out_valid_r || !out_stall;
  assign en2 = !s2_valid_r || en3;
  assign en1 = !s1_valid_r || en2;
  assign in_stall = !en1;

  // Stage 1 combinational decode.
  kind_t      kind_c;
  logic       a_zero_c, b_zero_c, div_c;
  gf_elem_t   log_b_c;
  gf_elem_t   log_b_nxt;

  assign kind_c   = kind_t'(in_kind);
  assign div_c    = (kind_c == KIND_DIV);
  assign a_zero_c = (in_left_operand == '0);
  assign b_zero_c = (in_right_operand == '0);
  assign log_b_c  = GF_LOG[in_right_operand];
  // Invert by negating the log; log b is at most 254 so this stays in 1..255.
  assign log_b_nxt = div_c ? (8'(GF_ORDER) - log_b_c) : log_b_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sum_r   <= (kind_c == KIND_ADD) || (kind_c == KIND_SUB);
      s1_zero_r  <= a_zero_c || b_zero_c;
      s1_dz_r    <= div_c && b_zero_c;
      s1_xor_r   <= in_left_operand ^ in_right_operand;
      s1_log_a_r <= GF_LOG[in_left_operand];
      s1_log_b_r <= log_b_nxt;
    end
  end

  // Stage 2: add logs, fold once since the sum stays below 2 * 255.
  logic [8:0] exp_sum_c;
  logic [8:0] exp_fold_c;

  assign exp_sum_c  = {1'b0, s1_log_a_r} + {1'b0, s1_log_b_r};
  assign exp_fold_c = (exp_sum_c >= 9'(GF_ORDER)) ? (exp_sum_c - 9'(GF_ORDER)) : exp_sum_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_sum_r  <= s1_sum_r;
      s2_zero_r <= s1_zero_r;
      s2_dz_r   <= s1_dz_r;
      s2_xor_r  <= s1_xor_r;
      s2_exp_r  <= exp_fold_c[7:0];
    end
  end

  // Stage 3: antilog and final select.
  gf_elem_t result_nxt;

  always_comb begin
    if (s2_sum_r) begin
      result_nxt = s2_xor_r;
    end else if (s2_zero_r) begin
      result_nxt = '0;
    end else begin
      result_nxt = GF_EXP[s2_exp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_result_r <= result_nxt;
      out_dz_r     <= s2_dz_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_field_result   = out_result_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

/* src/gau_checker.sv */
// Checker: port-level assertions for the GF(2^8) arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module gau_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_field_result,
  input logic       out_divide_by_zero
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_result)
      && $stable(out_divide_by_zero))
    else $error("stalled result changed");

  // A divide by zero always returns zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_field_result == 8'h00)
    else $error("divide by zero with nonzero result");

  // The input can only back up when the output is held.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gf256_arithmetic_unit gau_checker u_gau_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_field_result   (out_field_result),
  .out_divide_by_zero (out_divide_by_zero)
);
